// ===== sv/symtab_pkg.sv =====
// Shared types and constants for the compacting symbol table.
// Codes for functions, statuses and symbol kinds, plus the table geometry.
// No dependencies.
`timescale 1ns / 1ps

package symtab_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 128;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Special characters
   localparam logic [7:0] CHAR_TERM  = 8'h24; // '$'
   localparam logic [7:0] CHAR_PLUS  = 8'h2B; // '+'
   localparam logic [7:0] CHAR_MINUS = 8'h2D; // '-'
   localparam logic [7:0] CHAR_EQUAL = 8'h3D; // '='
   localparam logic [7:0] CHAR_STAR  = 8'h2A; // '*'

   typedef enum logic [1:0] {
      FUNC_SCAN   = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_READ   = 2'd2,
      FUNC_SPARE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_IDENT = 2'd0,
      KIND_OPER  = 2'd1,
      KIND_CONST = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      STAT_INSERTED   = 4'd0,
      STAT_DUPLICATE  = 4'd1,
      STAT_IGNORED    = 4'd2,
      STAT_DELETED    = 4'd3,
      STAT_NOT_FOUND  = 4'd4,
      STAT_FULL       = 4'd5,
      STAT_AFTER_TERM = 4'd6,
      STAT_READ_OK    = 4'd7,
      STAT_BAD_INDEX  = 4'd8
   } status_type;

   // One table entry as held in the memory
   typedef struct packed {
      kind_type   kind;
      logic [7:0] sym;
   } entry_type;

endpackage

// ===== sv/symbol_table_scan_insert_delete.sv =====
// Compacting symbol table: top level with sequencer, entry memory and result register.
// Depends on symtab_pkg.
`timescale 1ns / 1ps
//
//  chan | dir | handshake             | payload
//  -----+-----+-----------------------+---------------------------------------------------
//  req  | in  | req_tvalid/req_tready | tuser: func, expr_start; tdata: character, read_index
//  rsp  | out | rsp_tvalid/rsp_tready | tuser: status, kind; tdata: position, symbol_out, count
//
//  One item at a time; req_tready is high only while the sequencer is idle.
//  Scan and delete search the table through the single memory read port, one read and one
//  compare state per entry visited; delete then closes the gap with one read and one write state
//  per entry moved. After a miss, a scan appends the symbol (or reports a full table) and a
//  delete reports not found; every item ends by loading the output register.
//  Reset (synchronous, active high) empties the table; entry contents need no clearing.
//  A stalled rsp side holds the finished item in the output register and blocks the next one.

module symbol_table_scan_insert_delete (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] character, [14:8] read_index, [15] zero
   input  logic [7:0]  req_tuser,   // [1:0] func, [2] expr_start, [7:3] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [6:0] position, [14:7] symbol_out, [22:15] entry_count
   output logic [7:0]  rsp_tuser    // [3:0] status, [5:4] kind, [7:6] zero
);

   localparam int IDX_W = symtab_pkg::IDX_W;
   localparam int CNT_W = symtab_pkg::CNT_W;
   localparam int CW    = CNT_W + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_MISS,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_RD_WAIT,
      S_FINISH
   } state_type;

   // Input item fields
   symtab_pkg::func_type req_func;
   logic                 req_expr_start;
   logic [7:0]           req_character;
   logic [6:0]           req_read_index;

   assign req_func       = symtab_pkg::func_type'(req_tuser[1:0]);
   assign req_expr_start = req_tuser[2];
   assign req_character  = req_tdata[7:0];
   assign req_read_index = req_tdata[14:8];

   // Sequencer and table state
   state_type              state_ff, state_in;
   symtab_pkg::func_type   func_ff, func_in;
   logic [7:0]             char_ff, char_in;
   symtab_pkg::kind_type   ckind_ff, ckind_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   term_ff, term_in;

   // Result staging and output register
   symtab_pkg::status_type res_status_ff, res_status_in;
   logic [6:0]             res_pos_ff, res_pos_in;
   logic [7:0]             res_sym_ff, res_sym_in;
   symtab_pkg::kind_type   res_kind_ff, res_kind_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   symtab_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [6:0]             rsp_pos_ff, rsp_pos_in;
   logic [7:0]             rsp_sym_ff, rsp_sym_in;
   symtab_pkg::kind_type   rsp_kind_ff, rsp_kind_in;
   logic [7:0]             rsp_count_ff, rsp_count_in;

   // Entry memory
   symtab_pkg::entry_type  mem [symtab_pkg::TABLE_DEPTH];
   symtab_pkg::entry_type  rd_data_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   symtab_pkg::entry_type  mem_wdata;

   logic                   term_now;
   symtab_pkg::kind_type   req_kind;

   function automatic symtab_pkg::kind_type classify(input logic [7:0] c);
      symtab_pkg::kind_type k;
      k = symtab_pkg::KIND_NONE;
      if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
         k = symtab_pkg::KIND_IDENT;
      end else if (c == symtab_pkg::CHAR_PLUS || c == symtab_pkg::CHAR_MINUS ||
                   c == symtab_pkg::CHAR_EQUAL || c == symtab_pkg::CHAR_STAR) begin
         k = symtab_pkg::KIND_OPER;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         k = symtab_pkg::KIND_CONST;
      end
      return k;
   endfunction

   assign req_kind   = classify(req_character);
   assign term_now   = req_expr_start ? 1'b0 : term_ff;
   assign req_tready = (state_ff == S_IDLE);

   // Next-state and datapath control
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      char_in       = char_ff;
      ckind_in      = ckind_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      term_in       = term_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_sym_in    = res_sym_ff;
      res_kind_in   = res_kind_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_count_in  = rsp_count_ff;
      rd_addr       = idx_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = rd_data_ff;

      // Drop the output item once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in       = req_func;
               char_in       = req_character;
               ckind_in      = req_kind;
               idx_in        = '0;
               res_status_in = symtab_pkg::STAT_IGNORED;
               res_pos_in    = '0;
               res_sym_in    = '0;
               res_kind_in   = symtab_pkg::KIND_IDENT;
               state_in      = S_FINISH;
               case (req_func)
                  symtab_pkg::FUNC_SCAN: begin
                     term_in = term_now;
                     if (term_now) begin
                        res_status_in = symtab_pkg::STAT_AFTER_TERM;
                     end else if (req_character == symtab_pkg::CHAR_TERM) begin
                        term_in = 1'b1;
                     end else if (req_kind != symtab_pkg::KIND_NONE) begin
                        state_in = (count_ff == '0) ? S_MISS : S_SRCH_RD;
                     end
                  end
                  symtab_pkg::FUNC_DELETE: begin
                     state_in = (count_ff == '0) ? S_MISS : S_SRCH_RD;
                  end
                  symtab_pkg::FUNC_READ: begin
                     res_pos_in = req_read_index;
                     if (CW'(req_read_index) < CW'(count_ff)) begin
                        rd_addr  = IDX_W'(req_read_index);
                        state_in = S_RD_WAIT;
                     end else begin
                        res_status_in = symtab_pkg::STAT_BAD_INDEX;
                     end
                  end
                  default: begin
                     res_status_in = symtab_pkg::STAT_IGNORED;
                  end
               endcase
            end
         end

         // Fetch the entry under the search pointer
         S_SRCH_RD: begin
            rd_addr  = idx_ff;
            state_in = S_SRCH_CMP;
         end

         // Compare one entry, advance or finish
         S_SRCH_CMP: begin
            if (rd_data_ff.sym == char_ff) begin
               res_pos_in  = 7'(idx_ff);
               res_sym_in  = rd_data_ff.sym;
               res_kind_in = rd_data_ff.kind;
               if (func_ff == symtab_pkg::FUNC_SCAN) begin
                  res_status_in = symtab_pkg::STAT_DUPLICATE;
                  state_in      = S_FINISH;
               end else begin
                  res_status_in = symtab_pkg::STAT_DELETED;
                  if (CW'(idx_ff) + CW'(1) < CW'(count_ff)) begin
                     state_in = S_SHIFT_RD;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                     state_in = S_FINISH;
                  end
               end
            end else if (CW'(idx_ff) + CW'(1) < CW'(count_ff)) begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_SRCH_RD;
            end else begin
               state_in = S_MISS;
            end
         end

         // Symbol absent: report, or append a new entry
         S_MISS: begin
            res_pos_in  = '0;
            res_sym_in  = '0;
            res_kind_in = symtab_pkg::KIND_IDENT;
            state_in    = S_FINISH;
            if (func_ff == symtab_pkg::FUNC_DELETE) begin
               res_status_in = symtab_pkg::STAT_NOT_FOUND;
            end else if (count_ff == CNT_W'(symtab_pkg::TABLE_DEPTH)) begin
               res_status_in = symtab_pkg::STAT_FULL;
            end else begin
               mem_we         = 1'b1;
               mem_waddr      = IDX_W'(count_ff);
               mem_wdata.sym  = char_ff;
               mem_wdata.kind = ckind_ff;
               count_in       = count_ff + CNT_W'(1);
               res_status_in  = symtab_pkg::STAT_INSERTED;
               res_pos_in     = 7'(count_ff);
               res_sym_in     = char_ff;
               res_kind_in    = ckind_ff;
            end
         end

         // Close the gap: fetch the next entry
         S_SHIFT_RD: begin
            rd_addr  = idx_ff + IDX_W'(1);
            state_in = S_SHIFT_WR;
         end

         // Close the gap: move it down one place
         S_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = rd_data_ff;
            idx_in    = idx_ff + IDX_W'(1);
            if (CW'(idx_ff) + CW'(2) < CW'(count_ff)) begin
               state_in = S_SHIFT_RD;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_FINISH;
            end
         end

         S_RD_WAIT: begin
            res_status_in = symtab_pkg::STAT_READ_OK;
            res_sym_in    = rd_data_ff.sym;
            res_kind_in   = rd_data_ff.kind;
            state_in      = S_FINISH;
         end

         // Hand the item to the output register when it is free
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_sym_in    = res_sym_ff;
               rsp_kind_in   = res_kind_ff;
               rsp_count_in  = 8'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         term_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      char_ff       <= char_in;
      ckind_ff      <= ckind_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_sym_ff    <= res_sym_in;
      res_kind_ff   <= res_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_sym_ff, rsp_pos_ff};
   assign rsp_tuser  = {2'b00, rsp_kind_ff, rsp_status_ff};

   // Table never holds more entries than it has places
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(count_ff) <= CW'(symtab_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // Gap closing only happens for a delete
   a_shift_delete: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_RD || state_ff == S_SHIFT_WR) |->
         func_ff == symtab_pkg::FUNC_DELETE)
      else $error("shift sequence outside a delete");

   // An accepted item keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new item accepted while one is in progress");

   // Count moves by at most one per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CNT_W'(1)) ||
      (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("entry count jumped");

endmodule
